@@ src/ihc_pkg.sv @@
`default_nettype none

package ihc_pkg;

  // Frame layout
  localparam int unsigned ETH_HEADER_BYTES = 14;
  localparam int unsigned IP_HEADER_BYTES  = 20;
  localparam int unsigned POS_W            = 6;

  localparam logic [POS_W-1:0] POS_ET_HI  = POS_W'(ETH_HEADER_BYTES - 2);
  localparam logic [POS_W-1:0] POS_ET_LO  = POS_W'(ETH_HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] POS_IHL    = POS_W'(ETH_HEADER_BYTES + 0);
  localparam logic [POS_W-1:0] POS_TOS    = POS_W'(ETH_HEADER_BYTES + 1);
  localparam logic [POS_W-1:0] POS_TOT_HI = POS_W'(ETH_HEADER_BYTES + 2);
  localparam logic [POS_W-1:0] POS_TOT_LO = POS_W'(ETH_HEADER_BYTES + 3);
  localparam logic [POS_W-1:0] POS_ID_HI  = POS_W'(ETH_HEADER_BYTES + 4);
  localparam logic [POS_W-1:0] POS_ID_LO  = POS_W'(ETH_HEADER_BYTES + 5);
  localparam logic [POS_W-1:0] POS_FRG_HI = POS_W'(ETH_HEADER_BYTES + 6);
  localparam logic [POS_W-1:0] POS_FRG_LO = POS_W'(ETH_HEADER_BYTES + 7);
  localparam logic [POS_W-1:0] POS_TTL    = POS_W'(ETH_HEADER_BYTES + 8);
  localparam logic [POS_W-1:0] POS_PROTO  = POS_W'(ETH_HEADER_BYTES + 9);
  localparam logic [POS_W-1:0] POS_IP_END = POS_W'(ETH_HEADER_BYTES + IP_HEADER_BYTES - 1);

  // EtherType codes
  localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
  localparam logic [15:0] ETHERTYPE_MIN_II = 16'h0600;

  // Frame kinds
  typedef enum logic [1:0] {
    KIND_IPV4  = 2'd0,
    KIND_OTHER = 2'd1,
    KIND_8023  = 2'd2
  } frame_kind_e;

  // IP protocol numbers
  localparam logic [7:0] IPPROTO_ICMP = 8'h01;
  localparam logic [7:0] IPPROTO_IGMP = 8'h02;
  localparam logic [7:0] IPPROTO_IPIP = 8'h04;
  localparam logic [7:0] IPPROTO_TCP  = 8'h06;
  localparam logic [7:0] IPPROTO_UDP  = 8'h11;
  localparam logic [7:0] IPPROTO_IPV6 = 8'h29;
  localparam logic [7:0] IPPROTO_OSPF = 8'h59;

  // Protocol classes
  localparam logic [2:0] PC_ICMP  = 3'd0;
  localparam logic [2:0] PC_IGMP  = 3'd1;
  localparam logic [2:0] PC_IPIP  = 3'd2;
  localparam logic [2:0] PC_TCP   = 3'd3;
  localparam logic [2:0] PC_UDP   = 3'd4;
  localparam logic [2:0] PC_IPV6  = 3'd5;
  localparam logic [2:0] PC_OSPF  = 3'd6;
  localparam logic [2:0] PC_OTHER = 3'd7;
  localparam int unsigned NUM_PROTO_CNT = 7;

  // Size bins
  localparam logic [15:0] SIZE_LIM0 = 16'd160;
  localparam logic [15:0] SIZE_LIM1 = 16'd640;
  localparam logic [15:0] SIZE_LIM2 = 16'd1280;
  localparam logic [15:0] SIZE_LIM3 = 16'd5120;
  localparam int unsigned NUM_SIZE_CNT = 5;

  // Fragment flags and classes
  localparam logic [15:0] FRAG_DF       = 16'h4000;
  localparam logic [15:0] FRAG_MF       = 16'h2000;
  localparam logic [15:0] FRAG_OFS_MASK = 16'h1FFF;
  localparam logic [2:0]  FC_DF     = 3'd0;
  localparam logic [2:0]  FC_FIRST  = 3'd1;
  localparam logic [2:0]  FC_MIDDLE = 3'd2;
  localparam logic [2:0]  FC_LAST   = 3'd3;
  localparam logic [2:0]  FC_ONLY   = 3'd4;

  localparam int unsigned OUT_CNT_W = 32;

  // Word handed from the parser to the statistics side
  typedef struct packed {
    frame_kind_e kind;
    logic [3:0]  ihl;
    logic [7:0]  tos;
    logic [15:0] tot;
    logic [15:0] id;
    logic [15:0] frag;
    logic [7:0]  ttl;
    logic [7:0]  proto;
  } hdr_word_t;

  function automatic logic [2:0] proto_class_f(input logic [7:0] p);
    logic [2:0] c;
    unique case (p)
      IPPROTO_ICMP: c = PC_ICMP;
      IPPROTO_IGMP: c = PC_IGMP;
      IPPROTO_IPIP: c = PC_IPIP;
      IPPROTO_TCP:  c = PC_TCP;
      IPPROTO_UDP:  c = PC_UDP;
      IPPROTO_IPV6: c = PC_IPV6;
      IPPROTO_OSPF: c = PC_OSPF;
      default:      c = PC_OTHER;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] size_bin_f(input logic [15:0] t);
    logic [2:0] b;
    if (t < SIZE_LIM0) b = 3'd0;
    else if (t < SIZE_LIM1) b = 3'd1;
    else if (t < SIZE_LIM2) b = 3'd2;
    else if (t < SIZE_LIM3) b = 3'd3;
    else b = 3'd4;
    return b;
  endfunction

  function automatic logic [2:0] frag_class_f(input logic [15:0] f);
    logic       mf;
    logic       zero_ofs;
    logic [2:0] c;
    mf       = (f & FRAG_MF) != 16'd0;
    zero_ofs = (f & FRAG_OFS_MASK) == 16'd0;
    if ((f & FRAG_DF) != 16'd0) c = FC_DF;
    else if (mf) c = zero_ofs ? FC_FIRST : FC_MIDDLE;
    else c = zero_ofs ? FC_ONLY : FC_LAST;
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/ihc_front.sv @@
`default_nettype none

module ihc_front import ihc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       frame_start_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output hdr_word_t       push_word_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic             done_q, done_d;
  logic [7:0]       et_hi_q;
  logic [3:0]       ihl_q;
  logic [7:0]       tos_q, ttl_q, proto_q;
  logic [15:0]      tot_q, id_q, frag_q;

  logic             accept;
  logic             cur_done;
  logic [POS_W-1:0] cur_pos;
  logic [15:0]      ethertype;

  // Stall only when the queue cannot take a word
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign cur_done  = frame_start_i ? 1'b0 : done_q;
  assign cur_pos   = frame_start_i ? '0 : pos_q;
  assign ethertype = {et_hi_q, data_byte_i};

  // Position tracking and word generation
  always_comb begin
    pos_d       = pos_q;
    done_d      = done_q;
    push_o      = 1'b0;
    push_word_o = '{kind: KIND_IPV4, ihl: ihl_q, tos: tos_q, tot: tot_q, id: id_q,
                    frag: frag_q, ttl: ttl_q, proto: proto_q};
    if (accept) begin
      done_d = cur_done;
      if (!cur_done) begin
        pos_d = cur_pos + 1'b1;
        if (cur_pos == POS_ET_LO) begin
          if (ethertype != ETHERTYPE_IPV4) begin
            push_o           = 1'b1;
            push_word_o.kind = (ethertype < ETHERTYPE_MIN_II) ? KIND_8023 : KIND_OTHER;
            done_d           = 1'b1;
          end
        end else if (cur_pos == POS_IP_END) begin
          push_o = 1'b1;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      done_q <= 1'b1;
    end else begin
      pos_q  <= pos_d;
      done_q <= done_d;
    end
  end

  // Header field capture
  always_ff @(posedge clk_i) begin
    if (accept && !cur_done) begin
      case (cur_pos)
        POS_ET_HI:  et_hi_q      <= data_byte_i;
        POS_IHL:    ihl_q        <= data_byte_i[3:0];
        POS_TOS:    tos_q        <= data_byte_i;
        POS_TOT_HI: tot_q[15:8]  <= data_byte_i;
        POS_TOT_LO: tot_q[7:0]   <= data_byte_i;
        POS_ID_HI:  id_q[15:8]   <= data_byte_i;
        POS_ID_LO:  id_q[7:0]    <= data_byte_i;
        POS_FRG_HI: frag_q[15:8] <= data_byte_i;
        POS_FRG_LO: frag_q[7:0]  <= data_byte_i;
        POS_TTL:    ttl_q        <= data_byte_i;
        POS_PROTO:  proto_q      <= data_byte_i;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/ihc_queue.sv @@
`default_nettype none

module ihc_queue import ihc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  hdr_word_t       push_word_i,
  output logic            full_o,
  output logic            valid_o,
  output hdr_word_t       word_o,
  input  wire logic       pop_i
);

  localparam int unsigned Depth = 2;

  hdr_word_t  mem_q [Depth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'(Depth);
  assign valid_o = count_q != 2'd0;
  assign word_o  = mem_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_word_i;
  end

endmodule

`default_nettype wire

@@ src/ihc_back.sv @@
`default_nettype none

module ihc_back import ihc_pkg::*; #(
  parameter int unsigned COUNTER_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  hdr_word_t        q_word_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       frame_kind_o,
  output logic [2:0]       protocol_class_o,
  output logic [31:0]      protocol_count_o,
  output logic [2:0]       size_bin_o,
  output logic [31:0]      size_count_o,
  output logic [5:0]       header_bytes_o,
  output logic [15:0]      total_bytes_o,
  output logic [15:0]      payload_bytes_o,
  output logic [7:0]       hop_limit_o,
  output logic [7:0]       service_type_o,
  output logic [2:0]       fragment_class_o,
  output logic [15:0]      datagram_id_o
);

  logic [COUNTER_BITS-1:0] proto_cnt_q [NUM_PROTO_CNT];
  logic [COUNTER_BITS-1:0] size_cnt_q  [NUM_SIZE_CNT];

  logic                    is_ip;
  logic [2:0]              pc;
  logic [2:0]              sb;
  logic                    pc_counted;
  logic [COUNTER_BITS-1:0] pc_next;
  logic [COUNTER_BITS-1:0] sb_next;
  logic [5:0]              hlen;
  logic [15:0]             payload;

  // Take a word when the output register is free or being drained
  assign pop_o = q_valid_i && (!out_valid_o || !out_stall_i);

  // Classification and counter increments
  assign is_ip      = q_word_i.kind == KIND_IPV4;
  assign pc         = proto_class_f(q_word_i.proto);
  assign sb         = size_bin_f(q_word_i.tot);
  assign pc_counted = pc != PC_OTHER;
  assign pc_next    = pc_counted ? proto_cnt_q[pc] + 1'b1 : '0;
  assign sb_next    = size_cnt_q[sb] + 1'b1;
  assign hlen       = {q_word_i.ihl, 2'b00};
  assign payload    = (q_word_i.tot > 16'(hlen)) ? q_word_i.tot - 16'(hlen) : 16'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
      for (int i = 0; i < NUM_PROTO_CNT; i++) proto_cnt_q[i] <= '0;
      for (int i = 0; i < NUM_SIZE_CNT; i++) size_cnt_q[i] <= '0;
    end else begin
      if (pop_o) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
      if (pop_o && is_ip) begin
        if (pc_counted) proto_cnt_q[pc] <= pc_next;
        size_cnt_q[sb] <= sb_next;
      end
    end
  end

  // Result register; non-IPv4 words carry only their kind
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      frame_kind_o     <= q_word_i.kind;
      protocol_class_o <= is_ip ? pc : 3'd0;
      protocol_count_o <= is_ip ? OUT_CNT_W'(pc_next) : '0;
      size_bin_o       <= is_ip ? sb : 3'd0;
      size_count_o     <= is_ip ? OUT_CNT_W'(sb_next) : '0;
      header_bytes_o   <= is_ip ? hlen : 6'd0;
      total_bytes_o    <= is_ip ? q_word_i.tot : 16'd0;
      payload_bytes_o  <= is_ip ? payload : 16'd0;
      hop_limit_o      <= is_ip ? q_word_i.ttl : 8'd0;
      service_type_o   <= is_ip ? q_word_i.tos : 8'd0;
      fragment_class_o <= is_ip ? frag_class_f(q_word_i.frag) : 3'd0;
      datagram_id_o    <= is_ip ? q_word_i.id : 16'd0;
    end
  end

endmodule

`default_nettype wire

@@ src/ipv4_header_classifier_stats.sv @@
// Channel  Direction  Handshake              Payload
// in       sink       in_valid_i/in_stall_o   data_byte_i, frame_start_i
// out      source     out_valid_o/out_stall_i frame_kind_o .. datagram_id_o
//
// One byte is taken per cycle unless in_stall_o is high; a completed record passes through
// the queue, then the result register. Without output stalls the parser sets throughput.
// Reset clears all statistics counters; bytes are ignored until a frame start.
// in_stall_o rises only when the two-word queue to the counter stage is full.
`default_nettype none

module ipv4_header_classifier_stats import ihc_pkg::*; #(
  parameter int unsigned COUNTER_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        frame_start_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       frame_kind_o,
  output logic [2:0]       protocol_class_o,
  output logic [31:0]      protocol_count_o,
  output logic [2:0]       size_bin_o,
  output logic [31:0]      size_count_o,
  output logic [5:0]       header_bytes_o,
  output logic [15:0]      total_bytes_o,
  output logic [15:0]      payload_bytes_o,
  output logic [7:0]       hop_limit_o,
  output logic [7:0]       service_type_o,
  output logic [2:0]       fragment_class_o,
  output logic [15:0]      datagram_id_o
);

  logic      q_full;
  logic      push;
  hdr_word_t push_word;
  logic      q_valid;
  hdr_word_t q_word;
  logic      pop;

  // Byte parser
  ihc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_word_o   (push_word)
  );

  // Decoupling queue
  ihc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .word_o      (q_word),
    .pop_i       (pop)
  );

  // Statistics and result register
  ihc_back #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_word_i         (q_word),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_kind_o     (frame_kind_o),
    .protocol_class_o (protocol_class_o),
    .protocol_count_o (protocol_count_o),
    .size_bin_o       (size_bin_o),
    .size_count_o     (size_count_o),
    .header_bytes_o   (header_bytes_o),
    .total_bytes_o    (total_bytes_o),
    .payload_bytes_o  (payload_bytes_o),
    .hop_limit_o      (hop_limit_o),
    .service_type_o   (service_type_o),
    .fragment_class_o (fragment_class_o),
    .datagram_id_o    (datagram_id_o)
  );

endmodule

`default_nettype wire

@@ src/ihc_checker.sv @@
`default_nettype none

module ihc_checker import ihc_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  frame_kind_o,
  input wire logic [2:0]  protocol_class_o,
  input wire logic [31:0] protocol_count_o,
  input wire logic [2:0]  size_bin_o,
  input wire logic [31:0] size_count_o,
  input wire logic [5:0]  header_bytes_o,
  input wire logic [15:0] total_bytes_o,
  input wire logic [15:0] payload_bytes_o,
  input wire logic [7:0]  hop_limit_o,
  input wire logic [7:0]  service_type_o,
  input wire logic [2:0]  fragment_class_o,
  input wire logic [15:0] datagram_id_o
);

  // A stalled word stays presented
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("out word dropped while stalled");

  // Non-IPv4 words carry zero counts, lengths, id, hop limit and service type
  a_non_ip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_kind_o != KIND_IPV4 |->
      protocol_count_o == 32'd0 && size_count_o == 32'd0 && total_bytes_o == 16'd0 &&
      datagram_id_o == 16'd0 && header_bytes_o == 6'd0 && hop_limit_o == 8'd0 &&
      service_type_o == 8'd0)
    else $error("non-IPv4 word with header fields");

  // Unclassified protocols report a zero count
  a_other_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_kind_o == KIND_IPV4 && protocol_class_o == PC_OTHER |->
      protocol_count_o == 32'd0)
    else $error("count given for unclassified protocol");

  // Payload never exceeds total length; bins and fragment classes in range; header bytes a multiple of four
  a_ip_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_kind_o == KIND_IPV4 |->
      payload_bytes_o <= total_bytes_o && size_bin_o <= 3'd4 &&
      fragment_class_o <= FC_ONLY && header_bytes_o[1:0] == 2'b00)
    else $error("IPv4 record fields out of range");

endmodule

bind ipv4_header_classifier_stats ihc_checker u_ihc_checker (.*);

`default_nettype wire

@@ dv/tb_top.sv @@
module tb_top;
  import ihc_pkg::*;

  // Size bin codes as the block reports them
  localparam logic [2:0] BIN_LT160  = 3'd0;
  localparam logic [2:0] BIN_LT640  = 3'd1;
  localparam logic [2:0] BIN_LT1280 = 3'd2;
  localparam logic [2:0] BIN_LT5120 = 3'd3;
  localparam logic [2:0] BIN_JUMBO  = 3'd4;

  localparam int unsigned WHOLE_FRAME = 999;

  // One record as it leaves the block
  typedef struct packed {
    frame_kind_e kind;
    logic [2:0]  pclass;
    logic [31:0] pcount;
    logic [2:0]  sbin;
    logic [31:0] scount;
    logic [5:0]  hbytes;
    logic [15:0] total;
    logic [15:0] payload;
    logic [7:0]  ttl;
    logic [7:0]  tos;
    logic [2:0]  fclass;
    logic [15:0] ident;
  } ihc_record_t;

  // Header tracker and record checker
  class ihc_scoreboard;
    ihc_record_t  exp_q[$];
    int unsigned  errors;
    int unsigned  records_seen;
    int unsigned  records_due;
    int unsigned  ipv4_due;
    bit           ignoring = 1'b1;
    bit [5:0]     at;
    bit [7:0]     et_hi;
    bit [7:0]     ip_hdr[10];
    bit [31:0]    proto_tally[NUM_PROTO_CNT];
    bit [31:0]    size_tally[NUM_SIZE_CNT];

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", msg);
    endtask

    function int unsigned pending();
      return exp_q.size();
    endfunction

    // Track one accepted word; returns 1 if the parser consumed it
    function bit note_word(logic [7:0] d, logic st);
      ihc_record_t r;
      bit [5:0]    p;
      int unsigned k;
      logic [15:0] et;
      logic [15:0] tot;
      logic [15:0] frag;
      logic [5:0]  hl;
      logic [2:0]  pc;
      logic [2:0]  bin;
      if (st) begin
        at = '0;
        ignoring = 1'b0;
      end
      if (ignoring) return 1'b0;
      p = at;
      at = at + 6'd1;

      // Ethernet header: only the EtherType matters
      if (p < ETH_HEADER_BYTES) begin
        if (p == POS_ET_HI) begin
          et_hi = d;
        end else if (p == POS_ET_LO) begin
          et = {et_hi, d};
          if (et != ETHERTYPE_IPV4) begin
            r = '0;
            r.kind = (et < ETHERTYPE_MIN_II) ? KIND_8023 : KIND_OTHER;
            exp_q.push_back(r);
            records_due++;
            ignoring = 1'b1;
          end
        end
        return 1'b1;
      end

      k = p - ETH_HEADER_BYTES;
      if (k < 10) ip_hdr[k] = d;
      if (p != POS_IP_END) return 1'b1;

      // Last IPv4 header byte: build the record
      hl   = {ip_hdr[0][3:0], 2'b00};
      tot  = {ip_hdr[2], ip_hdr[3]};
      frag = {ip_hdr[6], ip_hdr[7]};
      case (ip_hdr[9])
        IPPROTO_ICMP: pc = PC_ICMP;
        IPPROTO_IGMP: pc = PC_IGMP;
        IPPROTO_IPIP: pc = PC_IPIP;
        IPPROTO_TCP:  pc = PC_TCP;
        IPPROTO_UDP:  pc = PC_UDP;
        IPPROTO_IPV6: pc = PC_IPV6;
        IPPROTO_OSPF: pc = PC_OSPF;
        default:      pc = PC_OTHER;
      endcase
      if (tot < SIZE_LIM0) bin = BIN_LT160;
      else if (tot < SIZE_LIM1) bin = BIN_LT640;
      else if (tot < SIZE_LIM2) bin = BIN_LT1280;
      else if (tot < SIZE_LIM3) bin = BIN_LT5120;
      else bin = BIN_JUMBO;

      r = '0;
      r.kind = KIND_IPV4;
      r.pclass = pc;
      if (pc != PC_OTHER) begin
        proto_tally[pc] = proto_tally[pc] + 32'd1;
        r.pcount = proto_tally[pc];
      end
      size_tally[bin] = size_tally[bin] + 32'd1;
      r.sbin    = bin;
      r.scount  = size_tally[bin];
      r.hbytes  = hl;
      r.total   = tot;
      r.payload = (tot > 16'(hl)) ? tot - 16'(hl) : 16'd0;
      r.ttl     = ip_hdr[8];
      r.tos     = ip_hdr[1];
      r.ident   = {ip_hdr[4], ip_hdr[5]};
      if ((frag & FRAG_DF) != 16'd0) r.fclass = FC_DF;
      else if ((frag & FRAG_MF) != 16'd0)
        r.fclass = ((frag & FRAG_OFS_MASK) == 16'd0) ? FC_FIRST : FC_MIDDLE;
      else
        r.fclass = ((frag & FRAG_OFS_MASK) == 16'd0) ? FC_ONLY : FC_LAST;
      exp_q.push_back(r);
      records_due++;
      ipv4_due++;
      ignoring = 1'b1;
      return 1'b1;
    endfunction

    task cmp_field(string name, logic [31:0] want, logic [31:0] have);
      if (want !== have)
        report($sformatf("record %0d %s: expected %0h, got %0h",
                         records_seen, name, want, have));
    endtask

    // Compare one delivered record with the oldest expected one
    task check_word(ihc_record_t got);
      ihc_record_t want;
      if (exp_q.size() == 0) begin
        report($sformatf("record with none expected, kind %0d", got.kind));
        return;
      end
      want = exp_q.pop_front();
      records_seen++;
      cmp_field("frame_kind", 32'(want.kind), 32'(got.kind));
      cmp_field("protocol_class", 32'(want.pclass), 32'(got.pclass));
      cmp_field("protocol_count", want.pcount, got.pcount);
      cmp_field("size_bin", 32'(want.sbin), 32'(got.sbin));
      cmp_field("size_count", want.scount, got.scount);
      cmp_field("header_bytes", 32'(want.hbytes), 32'(got.hbytes));
      cmp_field("total_bytes", 32'(want.total), 32'(got.total));
      cmp_field("payload_bytes", 32'(want.payload), 32'(got.payload));
      cmp_field("hop_limit", 32'(want.ttl), 32'(got.ttl));
      cmp_field("service_type", 32'(want.tos), 32'(got.tos));
      cmp_field("fragment_class", 32'(want.fclass), 32'(got.fclass));
      cmp_field("datagram_id", 32'(want.ident), 32'(got.ident));
    endtask
  endclass

  // Clock, reset and block inputs
  logic clk_i      = 1'b0;
  logic rst_ni     = 1'b0;
  logic in_valid   = 1'b0;
  logic [7:0] in_data = 8'h00;
  logic in_start   = 1'b0;
  logic out_stall  = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  frame_kind_o;
  logic [2:0]  protocol_class_o;
  logic [31:0] protocol_count_o;
  logic [2:0]  size_bin_o;
  logic [31:0] size_count_o;
  logic [5:0]  header_bytes_o;
  logic [15:0] total_bytes_o;
  logic [15:0] payload_bytes_o;
  logic [7:0]  hop_limit_o;
  logic [7:0]  service_type_o;
  logic [2:0]  fragment_class_o;
  logic [15:0] datagram_id_o;

  ihc_scoreboard sb = new;
  ihc_record_t   got_rec;
  logic [7:0]    frame_q[$];
  bit            calm_in;
  int unsigned   words_used;

  always #1 clk_i = ~clk_i;

  ipv4_header_classifier_stats i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (in_data),
    .frame_start_i    (in_start),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .frame_kind_o     (frame_kind_o),
    .protocol_class_o (protocol_class_o),
    .protocol_count_o (protocol_count_o),
    .size_bin_o       (size_bin_o),
    .size_count_o     (size_count_o),
    .header_bytes_o   (header_bytes_o),
    .total_bytes_o    (total_bytes_o),
    .payload_bytes_o  (payload_bytes_o),
    .hop_limit_o      (hop_limit_o),
    .service_type_o   (service_type_o),
    .fragment_class_o (fragment_class_o),
    .datagram_id_o    (datagram_id_o)
  );

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Send one word, holding it until the block takes it
  task automatic send_byte(logic [7:0] d, logic st);
    int unsigned g;
    g = pick_gap(calm_in);
    repeat (g) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= d;
    in_start <= st;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (sb.note_word(d, st)) words_used++;
  endtask

  // Frame assembly
  function automatic void put_eth(logic [15:0] et);
    frame_q.delete();
    repeat (12) frame_q.push_back(8'($urandom));
    frame_q.push_back(et[15:8]);
    frame_q.push_back(et[7:0]);
  endfunction

  function automatic void put_ip(logic [7:0] vihl, logic [7:0] tos, logic [15:0] tot,
                                 logic [15:0] ident, logic [15:0] frag, logic [7:0] ttl,
                                 logic [7:0] proto);
    frame_q.push_back(vihl);
    frame_q.push_back(tos);
    frame_q.push_back(tot[15:8]);
    frame_q.push_back(tot[7:0]);
    frame_q.push_back(ident[15:8]);
    frame_q.push_back(ident[7:0]);
    frame_q.push_back(frag[15:8]);
    frame_q.push_back(frag[7:0]);
    frame_q.push_back(ttl);
    frame_q.push_back(proto);
    // checksum and addresses
    repeat (10) frame_q.push_back(8'($urandom));
  endfunction

  // Send the first cut words of the assembled frame
  task automatic send_frame(int unsigned cut);
    for (int unsigned i = 0; i < frame_q.size() && i < cut; i++)
      send_byte(frame_q[i], i == 0);
  endtask

  task automatic send_eth_only(logic [15:0] et);
    put_eth(et);
    send_frame(WHOLE_FRAME);
  endtask

  task automatic send_ip(logic [7:0] vihl, logic [7:0] tos, logic [15:0] tot,
                         logic [15:0] ident, logic [15:0] frag, logic [7:0] ttl,
                         logic [7:0] proto, int unsigned tail);
    put_eth(ETHERTYPE_IPV4);
    put_ip(vihl, tos, tot, ident, frag, ttl, proto);
    repeat (tail) frame_q.push_back(8'($urandom));
    send_frame(WHOLE_FRAME);
  endtask

  // IPv4 frame with fields aimed at the bin edges and flag combinations
  task automatic send_random_ip(int unsigned cut, int unsigned tail);
    logic [7:0]  vihl;
    logic [7:0]  proto;
    logic [15:0] tot;
    logic [15:0] frag;
    int unsigned r;
    vihl = ($urandom_range(0, 3) != 0) ? {4'h4, 4'($urandom_range(5, 15))} : 8'($urandom);
    r = $urandom_range(0, 15);
    case (r)
      0:  tot = SIZE_LIM0 - 16'd1;
      1:  tot = SIZE_LIM0;
      2:  tot = SIZE_LIM1 - 16'd1;
      3:  tot = SIZE_LIM1;
      4:  tot = SIZE_LIM2 - 16'd1;
      5:  tot = SIZE_LIM2;
      6:  tot = SIZE_LIM3 - 16'd1;
      7:  tot = SIZE_LIM3;
      8:  tot = 16'd0;
      9:  tot = 16'hFFFF;
      10, 11, 12: tot = 16'($urandom_range(0, 300));
      default: tot = 16'($urandom);
    endcase
    r = $urandom_range(0, 5);
    case (r)
      0: frag = FRAG_DF | 16'($urandom_range(0, 16'h3FFF));
      1: frag = FRAG_MF;
      2: frag = FRAG_MF | 16'($urandom_range(1, FRAG_OFS_MASK));
      3: frag = 16'($urandom_range(1, FRAG_OFS_MASK));
      4: frag = 16'd0;
      default: frag = 16'($urandom);
    endcase
    if (r < 5) frag[15] = 1'($urandom);
    case ($urandom_range(0, 9))
      0: proto = IPPROTO_ICMP;
      1: proto = IPPROTO_IGMP;
      2: proto = IPPROTO_IPIP;
      3: proto = IPPROTO_TCP;
      4: proto = IPPROTO_UDP;
      5: proto = IPPROTO_IPV6;
      6: proto = IPPROTO_OSPF;
      7: proto = 8'h00;
      default: proto = 8'($urandom);
    endcase
    put_eth(ETHERTYPE_IPV4);
    put_ip(vihl, 8'($urandom), tot, 16'($urandom), frag, 8'($urandom), proto);
    repeat (tail) frame_q.push_back(8'($urandom));
    send_frame(cut);
  endtask

  // Receiver back-pressure, with calm stretches
  initial begin
    int unsigned n;
    bit          calm_out;
    forever begin
      if ($urandom_range(0, 15) == 0) calm_out = ~calm_out;
      n = pick_gap(calm_out);
      repeat (n) begin
        @(negedge clk_i);
        out_stall <= 1'b1;
      end
      n = $urandom_range(1, 6);
      repeat (n) begin
        @(negedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // Check each delivered record
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      got_rec.kind    = frame_kind_e'(frame_kind_o);
      got_rec.pclass  = protocol_class_o;
      got_rec.pcount  = protocol_count_o;
      got_rec.sbin    = size_bin_o;
      got_rec.scount  = size_count_o;
      got_rec.hbytes  = header_bytes_o;
      got_rec.total   = total_bytes_o;
      got_rec.payload = payload_bytes_o;
      got_rec.ttl     = hop_limit_o;
      got_rec.tos     = service_type_o;
      got_rec.fclass  = fragment_class_o;
      got_rec.ident   = datagram_id_o;
      sb.check_word(got_rec);
    end
  end

  // Stimulus
  initial begin
    int unsigned r;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // stray words before any frame start
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // length frames and other EtherTypes at the boundaries
    send_eth_only(16'h0000);
    send_eth_only(ETHERTYPE_MIN_II - 16'd1);
    send_eth_only(ETHERTYPE_MIN_II);
    send_eth_only(16'hFFFF);
    // every protocol, size bin edge and fragment class
    send_ip(8'h4F, 8'hFF, 16'd0, 16'hFFFF, FRAG_DF, 8'h00, IPPROTO_ICMP, 0);
    send_ip(8'h45, 8'h00, SIZE_LIM0 - 16'd1, 16'h0000, FRAG_MF, 8'hFF, IPPROTO_IGMP, 0);
    send_ip(8'h45, 8'hA5, SIZE_LIM0, 16'h1234, FRAG_MF | 16'h0001, 8'h40, IPPROTO_IPIP, 0);
    send_ip(8'h40, 8'h5A, SIZE_LIM1 - 16'd1, 16'h8001, FRAG_OFS_MASK, 8'h01, IPPROTO_TCP, 0);
    send_ip(8'hF5, 8'h80, SIZE_LIM1, 16'h00FF, 16'h0000, 8'h80, IPPROTO_UDP, 0);
    send_ip(8'h46, 8'h01, SIZE_LIM2 - 16'd1, 16'hFF00, 16'h8000, 8'h7F, IPPROTO_IPV6, 0);
    send_ip(8'h45, 8'hE0, SIZE_LIM2, 16'h5555, FRAG_DF | FRAG_MF | FRAG_OFS_MASK, 8'hFE,
            IPPROTO_OSPF, 0);
    send_ip(8'h45, 8'h1C, SIZE_LIM3 - 16'd1, 16'hAAAA, 16'hA000, 8'h02, 8'hFF, 0);
    send_ip(8'h45, 8'h10, SIZE_LIM3, 16'h0001, 16'h0100, 8'h03, IPPROTO_TCP, 0);
    send_ip(8'h4F, 8'h00, 16'hFFFF, 16'h8000, FRAG_MF | 16'h1000, 8'h10, 8'h00, 0);
    // header length equal to total length
    send_ip(8'h45, 8'h00, 16'd20, 16'h0002, 16'h0000, 8'h40, IPPROTO_UDP, 0);
    // frame start in the middle of a header, then words past the header
    send_random_ip(25, 0);
    send_ip(8'h45, 8'h00, 16'd1500, 16'h0003, FRAG_DF, 8'h40, IPPROTO_TCP, 6);

    // Random frames: mostly well formed, some cut short, some noise
    while (words_used < 900) begin
      calm_in = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 55) begin
        send_random_ip(WHOLE_FRAME, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0);
      end else if (r < 67) begin
        case ($urandom_range(0, 2))
          0: send_eth_only(16'h0000);
          1: send_eth_only(ETHERTYPE_MIN_II - 16'd1);
          default: send_eth_only(16'($urandom_range(0, ETHERTYPE_MIN_II - 16'd1)));
        endcase
      end else if (r < 79) begin
        case ($urandom_range(0, 5))
          0: send_eth_only(ETHERTYPE_MIN_II);
          1: send_eth_only(ETHERTYPE_IPV4 - 16'd1);
          2: send_eth_only(ETHERTYPE_IPV4 + 16'd1);
          3: send_eth_only(16'hFFFF);
          default: send_eth_only(16'($urandom_range(ETHERTYPE_IPV4 + 16'd1, 16'hFFFF)));
        endcase
      end else if (r < 91) begin
        send_random_ip($urandom_range(1, 33), 0);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
      end
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d parsed bytes and %0d records (%0d IPv4), with gaps and stalls",
             words_used, sb.records_seen, sb.ipv4_due);
    $display("on both sides, frame restarts mid-header and stray words between frames.");
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("Timeout with %0d records outstanding", sb.pending());
    $display("== FAIL ==");
    $finish;
  end

endmodule
